// File: rtl/core/swmc_pkg.sv
// Shared constants, state encoding and inter-module structs of the sliding window median block.
package swmc_pkg;

  localparam int WINDOW_MAX  = 64;
  localparam int SAMPLE_BITS = 32;

  localparam int PTR_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
  localparam int CFG_W  = 7;
  localparam int IN_W   = 32;
  localparam int MED_W  = 32;
  localparam int COST_W = 48;
  localparam int SUM_W  = SAMPLE_BITS + CNT_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_RING_WAIT,
    ST_PASS,
    ST_FLUSH,
    ST_RESULT
  } swmc_state_t;

  typedef struct packed {
    logic                   we;
    logic [PTR_W-1:0]       waddr;
    logic [SAMPLE_BITS-1:0] wdata;
    logic                   re;
    logic [PTR_W-1:0]       raddr;
  } swmc_mem_req_t;

  typedef struct packed {
    logic                   clear;
    logic                   push;
    logic                   load;
    logic                   even;
    logic [PTR_W-1:0]       idx;
    logic [PTR_W-1:0]       med_idx;
    logic [SAMPLE_BITS-1:0] data;
  } swmc_stat_ctl_t;

endpackage

// File: rtl/core/swmc_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module swmc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/swmc_ctrl.sv
// Sequencer that evicts, inserts and streams the sorted window through merge passes.
module swmc_ctrl import swmc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_W-1:0]       cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [IN_W-1:0]        sample,
  output swmc_mem_req_t          ring_req,
  input  logic [SAMPLE_BITS-1:0] ring_rdata,
  output swmc_mem_req_t          sort_req,
  input  logic [SAMPLE_BITS-1:0] sort_rdata,
  output swmc_stat_ctl_t         stat_ctl,
  input  logic                   out_free
);

  swmc_state_t state, state_next;

  logic [CFG_W-1:0]       wlen;
  logic [CNT_W-1:0]       eff_len, half_len;
  logic [CNT_W-1:0]       fill, fill_next;
  logic [CNT_W-1:0]       rd_idx, rd_idx_next;
  logic [CNT_W-1:0]       wr_idx, wr_idx_next;
  logic [PTR_W-1:0]       rp, rp_next, rp_inc, oldest;
  logic [CNT_W:0]         oldest_sum;
  logic [SAMPLE_BITS-1:0] smp, rem_val, qd, qd_next, wr_data;
  logic                   d_valid, d_valid_next;
  logic                   qv, qv_next;
  logic                   inserted, inserted_next;
  logic                   removed, removed_next;
  logic                   do_ins, do_ins_next;
  logic                   do_rem, do_rem_next;
  logic                   accept, ins_pend, rem_pend, ins_now, keep_d, wr_en, capture_rem;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    if (wlen == '0) begin
      eff_len = CNT_W'(1);
    end else if (32'(wlen) > WINDOW_MAX) begin
      eff_len = CNT_W'(WINDOW_MAX);
    end else begin
      eff_len = CNT_W'(wlen);
    end
  end

  assign half_len = (eff_len - CNT_W'(1)) >> 1;

  assign oldest_sum = (CNT_W+1)'(rp) + (CNT_W+1)'(WINDOW_MAX) - (CNT_W+1)'(fill);
  assign oldest = (oldest_sum >= (CNT_W+1)'(WINDOW_MAX)) ?
                  PTR_W'(oldest_sum - (CNT_W+1)'(WINDOW_MAX)) : PTR_W'(oldest_sum);
  assign rp_inc = (rp == PTR_W'(WINDOW_MAX - 1)) ? '0 : rp + PTR_W'(1);

  assign ins_pend = do_ins && !inserted;
  assign rem_pend = do_rem && !removed;
  assign ins_now  = d_valid && ins_pend && (smp < sort_rdata);
  assign keep_d   = d_valid && !(rem_pend && (sort_rdata == rem_val));

  always_comb begin
    state_next    = state;
    fill_next     = fill;
    rp_next       = rp;
    rd_idx_next   = rd_idx;
    wr_idx_next   = wr_idx;
    d_valid_next  = 1'b0;
    qv_next       = qv;
    qd_next       = qd;
    inserted_next = inserted;
    removed_next  = removed;
    do_ins_next   = do_ins;
    do_rem_next   = do_rem;
    capture_rem   = 1'b0;
    wr_en         = 1'b0;
    wr_data       = qd;
    ring_req      = '0;
    sort_req      = '0;
    stat_ctl      = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        do_rem_next   = (fill >= eff_len);
        do_ins_next   = (fill <= eff_len);
        rd_idx_next   = '0;
        wr_idx_next   = '0;
        qv_next       = 1'b0;
        inserted_next = 1'b0;
        removed_next  = 1'b0;
        stat_ctl.clear = (fill <= eff_len);
        if (fill >= eff_len) begin
          ring_req.re    = 1'b1;
          ring_req.raddr = oldest;
          state_next     = ST_RING_WAIT;
        end else begin
          state_next = ST_PASS;
        end
      end
      ST_RING_WAIT: begin
        capture_rem = 1'b1;
        state_next  = ST_PASS;
      end
      ST_PASS: begin
        if (rd_idx < fill) begin
          sort_req.re    = 1'b1;
          sort_req.raddr = rd_idx[PTR_W-1:0];
          rd_idx_next    = rd_idx + CNT_W'(1);
          d_valid_next   = 1'b1;
        end
        if (d_valid && rem_pend && (sort_rdata == rem_val)) begin
          removed_next = 1'b1;
        end
        if (ins_now) begin
          inserted_next = 1'b1;
        end
        if (qv) begin
          wr_en   = 1'b1;
          wr_data = qd;
          qv_next = keep_d;
          qd_next = sort_rdata;
        end else if (ins_now) begin
          wr_en   = 1'b1;
          wr_data = smp;
          qv_next = keep_d;
          qd_next = sort_rdata;
        end else if (keep_d) begin
          wr_en   = 1'b1;
          wr_data = sort_rdata;
          qv_next = 1'b0;
        end
        if (!d_valid && (rd_idx == fill)) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (qv) begin
          wr_en   = 1'b1;
          wr_data = qd;
          qv_next = 1'b0;
        end else if (ins_pend) begin
          wr_en         = 1'b1;
          wr_data       = smp;
          inserted_next = 1'b1;
        end
        fill_next = fill + CNT_W'(do_ins) - CNT_W'(do_rem);
        if (do_ins) begin
          ring_req.we    = 1'b1;
          ring_req.waddr = rp;
          ring_req.wdata = smp;
          rp_next        = rp_inc;
          state_next     = (fill_next == eff_len) ? ST_RESULT : ST_IDLE;
        end else begin
          state_next = ST_EVAL;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          stat_ctl.load = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    sort_req.we    = wr_en;
    sort_req.waddr = wr_idx[PTR_W-1:0];
    sort_req.wdata = wr_data;
    if (wr_en) begin
      wr_idx_next = wr_idx + CNT_W'(1);
    end
    stat_ctl.push    = wr_en && do_ins;
    stat_ctl.idx     = wr_idx[PTR_W-1:0];
    stat_ctl.data    = wr_data;
    stat_ctl.med_idx = half_len[PTR_W-1:0];
    stat_ctl.even    = ~eff_len[0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      wlen     <= CFG_W'(1);
      fill     <= '0;
      rp       <= '0;
      rd_idx   <= '0;
      wr_idx   <= '0;
      d_valid  <= 1'b0;
      qv       <= 1'b0;
      inserted <= 1'b0;
      removed  <= 1'b0;
      do_ins   <= 1'b0;
      do_rem   <= 1'b0;
    end else begin
      state    <= state_next;
      if (cfg_we) begin
        wlen <= cfg_data;
      end
      fill     <= fill_next;
      rp       <= rp_next;
      rd_idx   <= rd_idx_next;
      wr_idx   <= wr_idx_next;
      d_valid  <= d_valid_next;
      qv       <= qv_next;
      inserted <= inserted_next;
      removed  <= removed_next;
      do_ins   <= do_ins_next;
      do_rem   <= do_rem_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      smp <= sample[SAMPLE_BITS-1:0];
    end
    if (capture_rem) begin
      rem_val <= ring_rdata;
    end
    qd <= qd_next;
  end

`ifndef NO_ASSERTIONS
  a_queue_single: assert property (@(posedge clk) disable iff (rst) qv |-> !ins_now)
    else $error("Merge queue would overflow.");
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
      (sort_req.we && sort_req.re) |-> (sort_req.waddr != sort_req.raddr))
    else $error("Sorted store read and written at the same entry.");
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
      fill <= CNT_W'(WINDOW_MAX))
    else $error("Fill count exceeds the window capacity.");
  a_pass_done_empty: assert property (@(posedge clk) disable iff (rst)
      (state == ST_FLUSH) |=> !qv)
    else $error("Merge queue not drained at the end of a pass.");
`endif

endmodule

// File: rtl/core/swmc_stat.sv
// Median capture, partial sums around the median and the result register.
module swmc_stat import swmc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  swmc_stat_ctl_t    ctl,
  output logic              out_free,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [MED_W-1:0]  median_value,
  output logic [COST_W-1:0] deviation_cost
);

  logic [SUM_W-1:0]       sum_lo, sum_hi;
  logic [SAMPLE_BITS-1:0] med;
  logic [COST_W-1:0]      cost_calc;

  assign out_free  = !out_valid || !out_stall;
  assign cost_calc = COST_W'(sum_hi) - COST_W'(sum_lo) - (ctl.even ? COST_W'(med) : '0);

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      sum_lo <= '0;
      sum_hi <= '0;
    end else if (ctl.push) begin
      if (ctl.idx < ctl.med_idx) begin
        sum_lo <= sum_lo + SUM_W'(ctl.data);
      end else if (ctl.idx == ctl.med_idx) begin
        med <= ctl.data;
      end else begin
        sum_hi <= sum_hi + SUM_W'(ctl.data);
      end
    end
    if (ctl.load) begin
      median_value   <= MED_W'(med);
      deviation_cost <= cost_calc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

`ifndef NO_ASSERTIONS
  a_load_free: assert property (@(posedge clk) disable iff (rst) ctl.load |-> out_free)
    else $error("Result loaded over a transaction still pending.");
  a_load_shows: assert property (@(posedge clk) disable iff (rst) ctl.load |=> out_valid)
    else $error("Loaded result not presented.");
  a_clear_push: assert property (@(posedge clk) disable iff (rst) !(ctl.clear && ctl.push))
    else $error("Accumulator cleared and updated in the same cycle.");
`endif

endmodule

// File: rtl/core/sliding_window_median_cost.sv
// A result is produced once the window holds window_len samples; samples before the window first fills give none.
// A new sample is accepted only when idle: each one runs a merge pass over the sorted-store RAM port,
// and a sample that produces a result also waits for the output to be free before the block idles again.
// Each extra eviction after the window shrinks adds another pass.
// Reset clears control state and sets window_len to 1; the RAMs are not cleared.
// Top level of the sliding window median and absolute deviation sum.
module sliding_window_median_cost import swmc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [IN_W-1:0]   sample,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [MED_W-1:0]  median_value,
  output logic [COST_W-1:0] deviation_cost
);

  swmc_mem_req_t          ring_req, sort_req;
  swmc_stat_ctl_t         stat_ctl;
  logic [SAMPLE_BITS-1:0] ring_rdata, sort_rdata;
  logic                   out_free;

  swmc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .sample    (sample),
    .ring_req  (ring_req),
    .ring_rdata(ring_rdata),
    .sort_req  (sort_req),
    .sort_rdata(sort_rdata),
    .stat_ctl  (stat_ctl),
    .out_free  (out_free)
  );

  swmc_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(WINDOW_MAX)) u_ring_ram (
    .clk  (clk),
    .we   (ring_req.we),
    .waddr(ring_req.waddr),
    .wdata(ring_req.wdata),
    .re   (ring_req.re),
    .raddr(ring_req.raddr),
    .rdata(ring_rdata)
  );

  swmc_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(WINDOW_MAX)) u_sort_ram (
    .clk  (clk),
    .we   (sort_req.we),
    .waddr(sort_req.waddr),
    .wdata(sort_req.wdata),
    .re   (sort_req.re),
    .raddr(sort_req.raddr),
    .rdata(sort_rdata)
  );

  swmc_stat u_stat (
    .clk           (clk),
    .rst           (rst),
    .ctl           (stat_ctl),
    .out_free      (out_free),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .median_value  (median_value),
    .deviation_cost(deviation_cost)
  );

endmodule

// File: sim/tb_top.sv
// Self-checking testbench of the sliding window median and deviation sum block.
module tb_top;
  import swmc_pkg::*;

  typedef struct {
    logic [MED_W-1:0]  median;
    logic [COST_W-1:0] cost;
  } window_result_t;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [CFG_W-1:0]  cfg_data;
  logic              in_valid;
  logic              in_stall;
  logic [IN_W-1:0]   sample;
  logic              out_valid;
  logic              out_stall;
  logic [MED_W-1:0]  median_value;
  logic [COST_W-1:0] deviation_cost;

  logic [31:0]       arrival_q [WINDOW_MAX];
  logic [31:0]       ordered_q [WINDOW_MAX];
  int unsigned       held_cnt;
  int unsigned       next_slot;
  logic [CFG_W-1:0]  window_reg;

  window_result_t    result_q [$];
  int                err_cnt;
  int unsigned       idle_pct;
  bit                hold_req;

  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = WINDOW_MAX + 16;

  sliding_window_median_cost u_top (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .sample         (sample),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .median_value   (median_value),
    .deviation_cost (deviation_cost)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Advances the window model by one sample and reports whether a result is due.
  function automatic bit window_median_step(input logic [31:0] s,
                                            output logic [MED_W-1:0] med,
                                            output logic [COST_W-1:0] cost);
    int unsigned len;
    int unsigned pos;
    int unsigned oldest;
    logic [31:0] victim;
    len = (window_reg == 0) ? 1 : ((window_reg > WINDOW_MAX) ? WINDOW_MAX : window_reg);
    while (held_cnt >= len) begin
      oldest = (next_slot + WINDOW_MAX - held_cnt) % WINDOW_MAX;
      victim = arrival_q[PTR_W'(oldest)];
      pos = 0;
      while (pos < held_cnt && ordered_q[PTR_W'(pos)] != victim) pos++;
      if (pos >= held_cnt) pos = held_cnt - 1;
      while (pos + 1 < held_cnt) begin
        ordered_q[PTR_W'(pos)] = ordered_q[PTR_W'(pos + 1)];
        pos++;
      end
      held_cnt--;
    end
    arrival_q[PTR_W'(next_slot)] = s;
    next_slot = (next_slot + 1) % WINDOW_MAX;
    pos = held_cnt;
    while (pos > 0 && ordered_q[PTR_W'(pos - 1)] > s) begin
      ordered_q[PTR_W'(pos)] = ordered_q[PTR_W'(pos - 1)];
      pos--;
    end
    ordered_q[PTR_W'(pos)] = s;
    held_cnt++;
    med = '0;
    cost = '0;
    if (held_cnt != len) return 1'b0;
    med = ordered_q[PTR_W'((held_cnt + 1) / 2 - 1)];
    for (int i = 0; i < held_cnt; i++) begin
      cost += (ordered_q[PTR_W'(i)] >= med) ? COST_W'(ordered_q[PTR_W'(i)] - med)
                                            : COST_W'(med - ordered_q[PTR_W'(i)]);
    end
    return 1'b1;
  endfunction

  function automatic logic [31:0] pick_sample();
    case ($urandom_range(9))
      0, 1:    return $urandom_range(15);
      2:       return $urandom_range(1000);
      3: begin
        case ($urandom_range(3))
          0:       return 32'h0000_0000;
          1:       return 32'hFFFF_FFFF;
          2:       return 32'h8000_0000;
          default: return 32'h7FFF_FFFF;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic send_sample(input logic [31:0] s);
    window_result_t r;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sample   <= s;
    do @(posedge clk); while (in_stall);
    if (window_median_step(s, r.median, r.cost)) result_q.push_back(r);
  endtask

  task automatic settle_idle();
    in_valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_window(input logic [CFG_W-1:0] len);
    settle_idle();
    cfg_we   <= 1'b1;
    cfg_data <= len;
    @(posedge clk);
    cfg_we     <= 1'b0;
    window_reg = len;
  endtask

  task automatic test_reset_window();
    send_sample(32'h0000_0000);
    send_sample(32'hFFFF_FFFF);
    send_sample(32'hAAAA_AAAA);
    send_sample(32'h5555_5555);
  endtask

  task automatic test_directed_cases();
    set_window(CFG_W'(0));
    send_sample(32'h0000_0001);
    send_sample(32'hFFFF_FFFE);
    set_window(CFG_W'(2));
    send_sample(32'h0000_0000);
    send_sample(32'hFFFF_FFFF);
    send_sample(32'hFFFF_FFFF);
    set_window(CFG_W'(3));
    send_sample(32'd7);
    send_sample(32'd7);
    send_sample(32'd3);
    send_sample(32'd7);
    set_window(CFG_W'(1));
    send_sample(32'd5);
    set_window(CFG_W'(4));
    send_sample(32'd1);
    send_sample(32'd2);
    send_sample(32'd3);
    send_sample(32'd4);
  endtask

  task automatic test_max_deviation();
    set_window(CFG_W'(127));
    for (int i = 0; i < WINDOW_MAX + 8; i++) begin
      send_sample((i % 2) ? 32'hFFFF_FFFF : 32'h0000_0000);
    end
  endtask

  task automatic test_random_windows();
    int unsigned sent;
    int unsigned phase;
    int unsigned len;
    int unsigned n;
    logic [CFG_W-1:0] w;
    sent  = 0;
    phase = 0;
    while (sent < 560) begin
      if (phase == 0) begin
        w = CFG_W'(WINDOW_MAX);
      end else begin
        case ($urandom_range(7))
          0:       w = CFG_W'(0);
          1:       w = CFG_W'(1);
          2:       w = CFG_W'(2);
          3:       w = CFG_W'(WINDOW_MAX);
          4:       w = CFG_W'(127);
          5:       w = CFG_W'($urandom_range(WINDOW_MAX + 1, 127));
          default: w = CFG_W'($urandom_range(3, 40));
        endcase
      end
      set_window(w);
      idle_pct = (phase == 2 || phase == 3) ? 0 : 13;
      len = (w == 0) ? 1 : ((w > WINDOW_MAX) ? WINDOW_MAX : w);
      n = len + $urandom_range(4, 30);
      for (int i = 0; i < n; i++) send_sample(pick_sample());
      sent += n;
      phase++;
    end
    idle_pct = 13;
  endtask

  task automatic test_output_hold();
    set_window(CFG_W'(4));
    hold_req = 1'b1;
    for (int i = 0; i < 40; i++) send_sample(pick_sample());
    while (hold_req) @(posedge clk);
  endtask

  initial begin
    out_stall = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < idle_pct);
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    window_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (result_q.size() == 0) begin
        $error("unexpected transaction: median_value %0h deviation_cost %0h",
               median_value, deviation_cost);
        err_cnt++;
      end else begin
        want = result_q.pop_front();
        if (median_value !== want.median) begin
          $error("median_value mismatch: expected %0h, actual %0h", want.median, median_value);
          err_cnt++;
        end
        if (deviation_cost !== want.cost) begin
          $error("deviation_cost mismatch: expected %0h, actual %0h", want.cost, deviation_cost);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

  initial begin
    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_data   = '0;
    in_valid   = 1'b0;
    sample     = '0;
    err_cnt    = 0;
    idle_pct   = 13;
    hold_req   = 1'b0;
    held_cnt   = 0;
    next_slot  = 0;
    window_reg = CFG_W'(1);
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_window();
    test_directed_cases();
    test_max_deviation();
    test_random_windows();
    test_output_hold();
    settle_idle();
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
